FILE: src/srig_pkg.sv
package srig_pkg;

    // Field and register widths
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 16;
    localparam int RAW_W  = 64;
    localparam int POP_W  = 17;
    localparam int HALF_W = RAW_W / 2;

    // Largest population the index reduction supports
    localparam int MAX_POPULATION = 65536;
    localparam int DIV_W = $clog2(MAX_POPULATION + 1);
    localparam int REM_W = $clog2(MAX_POPULATION);
    localparam int DCNT_W = $clog2(RAW_W);

    // Command codes
    localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd2;

    // Hash and mixer constants
    localparam logic [RAW_W-1:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [RAW_W-1:0] FNV_PRIME   = 64'h00000100000001b3;
    localparam logic [RAW_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [RAW_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [RAW_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FNV_DONE,
        ST_MIX_ADD,
        ST_MIX_X27,
        ST_MIX_X31,
        ST_GEN_SUM,
        ST_GEN_OUT,
        ST_DIV,
        ST_DIV_DONE
    } state_t;

    // Which constant the shared multiplier applies
    typedef enum logic [1:0] {
        MUL_FNV,
        MUL_A,
        MUL_B
    } mul_sel_t;

    function automatic logic [RAW_W-1:0] mul_const(input mul_sel_t sel);
        logic [RAW_W-1:0] c;
        unique case (sel)
            MUL_FNV: c = FNV_PRIME;
            MUL_A:   c = MIX_MUL_A;
            MUL_B:   c = MIX_MUL_B;
            default: c = FNV_PRIME;
        endcase
        return c;
    endfunction

endpackage

FILE: src/seeded_resample_index_generator.sv
// Draw: after acceptance, two generator steps, the radix-2 remainder loop (64 steps,
//   one bit each) and one output load run before the idle state and the next ready;
//   the load waits while an earlier result still waits at the output.
// Absorb: one 64-bit multiply as four 32x32 partial-product steps.
// Finish: four SplitMix64 steps, two multiplies each, on the one multiplier.
// Reset: synchronous, active low; afterwards a seeding pass from the
//   FNV offset basis runs with s_ready low. Population size resets to 1.
module seeded_resample_index_generator
    import srig_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [POP_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [BYTE_W-1:0] s_seed_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [IDX_W-1:0]  m_sample_index,
    output logic [RAW_W-1:0]  m_raw_value
);

    state_t              state_reg, state_next;
    mul_sel_t            mul_sel_reg;
    logic [1:0]          mul_cnt_reg;
    logic [1:0]          idx_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [POP_W-1:0]    pop_reg;
    logic [RAW_W-1:0]    hash_reg;
    logic [RAW_W-1:0]    ctr_reg;
    logic [RAW_W-1:0]    acc_reg;
    logic [RAW_W-1:0]    mop_reg;
    logic [RAW_W-1:0]    prod_reg;
    logic [RAW_W-1:0]    dsh_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RAW_W-1:0]    w_reg [4];
    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_idx_reg;
    logic [RAW_W-1:0]    m_raw_reg;

    logic                in_acc;
    logic                out_free;
    logic [RAW_W-1:0]    mul_b_full;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [RAW_W-1:0]    mul_p;
    logic [RAW_W-1:0]    mul_addend;
    logic [RAW_W-1:0]    ctr_step;
    logic [RAW_W-1:0]    gen_raw;
    logic [RAW_W-1:0]    gen_t, gen_n0, gen_n1, gen_n2, gen_n3;
    logic [POP_W-1:0]    div_eff;
    logic [REM_W:0]      div_trial;
    logic [REM_W:0]      div_ext;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Effective divisor: zero reads as one, large values saturate
    always_comb begin
        if (pop_reg == '0) begin
            div_eff = POP_W'(1);
        end else if (32'(pop_reg) > MAX_POPULATION) begin
            div_eff = POP_W'(MAX_POPULATION);
        end else begin
            div_eff = pop_reg;
        end
    end

    // Shared 32x32 multiplier; partial products lo*lo, lo*hi, hi*lo
    always_comb begin
        mul_b_full = mul_const(mul_sel_reg);
        unique case (mul_cnt_reg)
            2'd1: begin
                mul_a = mop_reg[HALF_W-1:0];
                mul_b = mul_b_full[RAW_W-1:HALF_W];
            end
            2'd2: begin
                mul_a = mop_reg[RAW_W-1:HALF_W];
                mul_b = mul_b_full[HALF_W-1:0];
            end
            default: begin
                mul_a = mop_reg[HALF_W-1:0];
                mul_b = mul_b_full[HALF_W-1:0];
            end
        endcase
    end
    assign mul_p = RAW_W'(mul_a) * RAW_W'(mul_b);

    // Cross products only matter in their low half, shifted up
    assign mul_addend = (mul_cnt_reg == 2'd1) ? prod_reg
                                              : {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    assign ctr_step = ctr_reg + GOLDEN_STEP;

    // xoshiro256++ output and state update
    assign gen_raw = {acc_reg[RAW_W-24:0], acc_reg[RAW_W-1:RAW_W-23]} + w_reg[0];
    always_comb begin
        gen_t  = w_reg[1] << 17;
        gen_n2 = w_reg[2] ^ w_reg[0];
        gen_n3 = w_reg[3] ^ w_reg[1];
        gen_n1 = w_reg[1] ^ gen_n2;
        gen_n0 = w_reg[0] ^ gen_n3;
        gen_n2 = gen_n2 ^ gen_t;
        gen_n3 = {gen_n3[RAW_W-46:0], gen_n3[RAW_W-1:RAW_W-45]};
    end

    // One restoring remainder step
    assign div_trial = {rem_reg, dsh_reg[RAW_W-1]};
    assign div_ext   = (REM_W+1)'(div_eff);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (s_op == OP_ABSORB) begin
                        state_next = ST_MUL;
                    end else if (s_op == OP_FINISH) begin
                        state_next = ST_MIX_ADD;
                    end else if (s_op == OP_DRAW) begin
                        state_next = ST_GEN_SUM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                if (mul_cnt_reg == 2'd3) begin
                    unique case (mul_sel_reg)
                        MUL_FNV: state_next = ST_FNV_DONE;
                        MUL_A:   state_next = ST_MIX_X27;
                        MUL_B:   state_next = ST_MIX_X31;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FNV_DONE: state_next = ST_IDLE;
            ST_MIX_ADD:  state_next = ST_MUL;
            ST_MIX_X27:  state_next = ST_MUL;
            ST_MIX_X31:  state_next = (idx_reg == 2'd3) ? ST_IDLE : ST_MIX_ADD;
            ST_GEN_SUM:  state_next = ST_GEN_OUT;
            ST_GEN_OUT:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == DCNT_W'(RAW_W - 1)) begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        m_valid        = m_valid_reg;
        m_sample_index = m_idx_reg;
        m_raw_value    = m_raw_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_MIX_ADD;
            idx_reg     <= '0;
            mul_cnt_reg <= '0;
            mul_sel_reg <= MUL_A;
            div_cnt_reg <= '0;
            pop_reg     <= POP_W'(1);
            hash_reg    <= FNV_BASIS;
            ctr_reg     <= FNV_BASIS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                pop_reg <= cfg_wdata;
            end
            // result register: load on the output step, clear once taken
            if (state_reg == ST_DIV_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_op == OP_ABSORB) begin
                        mul_sel_reg <= MUL_FNV;
                        mul_cnt_reg <= '0;
                    end
                    if (in_acc && s_op == OP_FINISH) begin
                        ctr_reg <= hash_reg;
                        idx_reg <= '0;
                    end
                end
                ST_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                end
                ST_FNV_DONE: begin
                    hash_reg <= acc_reg;
                end
                ST_MIX_ADD: begin
                    ctr_reg     <= ctr_step;
                    mul_sel_reg <= MUL_A;
                    mul_cnt_reg <= '0;
                end
                ST_MIX_X27: begin
                    mul_sel_reg <= MUL_B;
                    mul_cnt_reg <= '0;
                end
                ST_MIX_X31: begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        hash_reg <= FNV_BASIS;
                    end
                end
                ST_GEN_OUT: begin
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_op == OP_ABSORB) begin
                    mop_reg <= hash_reg ^ RAW_W'(s_seed_byte);
                end
            end
            ST_MUL: begin
                prod_reg <= mul_p;
                if (mul_cnt_reg == 2'd0) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + mul_addend;
                end
            end
            ST_MIX_ADD: begin
                mop_reg <= ctr_step ^ (ctr_step >> 30);
            end
            ST_MIX_X27: begin
                mop_reg <= acc_reg ^ (acc_reg >> 27);
            end
            ST_MIX_X31: begin
                w_reg[idx_reg] <= acc_reg ^ (acc_reg >> 31);
            end
            ST_GEN_SUM: begin
                acc_reg <= w_reg[0] + w_reg[3];
            end
            ST_GEN_OUT: begin
                acc_reg  <= gen_raw;
                dsh_reg  <= gen_raw;
                rem_reg  <= '0;
                w_reg[0] <= gen_n0;
                w_reg[1] <= gen_n1;
                w_reg[2] <= gen_n2;
                w_reg[3] <= gen_n3;
            end
            ST_DIV: begin
                dsh_reg <= dsh_reg << 1;
                if (div_trial >= div_ext) begin
                    rem_reg <= REM_W'(div_trial - div_ext);
                end else begin
                    rem_reg <= REM_W'(div_trial);
                end
            end
            ST_DIV_DONE: begin
                if (out_free) begin
                    m_idx_reg <= IDX_W'(rem_reg);
                    m_raw_reg <= acc_reg;
                end
            end
            default: ;
        endcase
    end

    // Checks
    a_result_from_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DIV_DONE)
        else $error("result raised outside the output load step");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (POP_W'(m_idx_reg) < div_eff))
        else $error("sample index not below the population size");

    a_busy_after_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_op == OP_DRAW) |=> !s_ready ##1 !s_ready)
        else $error("input taken while a draw is in progress");

endmodule
